/* design/rspu_pkg.sv */
package rspu_pkg;

  // Configuration
  localparam int          CFG_W        = 10;
  localparam int          MAX_HEAD_DEF = 512;
  localparam logic [9:0]  HEAD_RST     = 10'd256;
  localparam logic [9:0]  ROT_RST      = 10'd64;

  // Result word fields and queue depth
  localparam int          POS_W        = 9;
  localparam int          OQ_DEPTH     = 16;

  // fp16 codes
  localparam logic [15:0] HALF_QNAN    = 16'h7E00;
  localparam logic [14:0] HALF_INF     = 15'h7C00;

  typedef enum logic {
    CFG_HEAD = 1'b0,
    CFG_ROT  = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] element_value;
    logic [15:0] cos_value;
    logic [15:0] sin_value;
  } in_word_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic [15:0]      result_value;
    logic             run_last;
    logic             head_last;
  } out_word_t;

  // Per-item control that rides along the arithmetic pipe
  typedef struct packed {
    logic             pair;
    logic [POS_W-1:0] pos_a;
    logic [POS_W-1:0] pos_b;
    logic             last;
  } rot_ctl_t;

  // One queue entry: all result words of one item
  typedef struct packed {
    logic             pair;
    logic [POS_W-1:0] pos_a;
    logic [15:0]      val_a;
    logic [POS_W-1:0] pos_b;
    logic [15:0]      val_b;
    logic             last;
  } ent_t;

endpackage

/* design/rope_split_half_partial_unit.sv */
// Throughput: one input word per cycle while in_stall_o is low; a rotated second-half element
//   yields two result words, delivered one after the other; the 16-entry result queue
//   raises in_stall_o when 16 items with results are pending.
// Reset: element counter cleared, registers to head 256 / rotary 64, queue empty;
//   the first-half store is not cleared.
module rope_split_half_partial_unit #(
  parameter int MaxHead = rspu_pkg::MAX_HEAD_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  rspu_pkg::in_word_t         in_word_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output rspu_pkg::out_word_t        out_word_o,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [rspu_pkg::CFG_W-1:0] cfg_wdata_i
);
  import rspu_pkg::*;

  localparam int CntW   = $clog2(MaxHead);
  localparam int HW     = (CntW + 1 > CFG_W) ? CntW + 1 : CFG_W;
  localparam int StDep  = MaxHead / 2;
  localparam int AW     = $clog2(StDep);
  localparam int OccW   = $clog2(OQ_DEPTH) + 1;

  function automatic logic [HW-1:0] sat_head(logic [CFG_W-1:0] v);
    logic [HW-1:0] t;
    t = HW'(v);
    if (t < HW'(2)) t = HW'(2);
    if (t > HW'(MaxHead)) t = HW'(MaxHead);
    return t;
  endfunction

  function automatic logic [HW-1:0] sat_rot(logic [CFG_W-1:0] v, logic [HW-1:0] h);
    logic [HW-1:0] t;
    t = HW'({v[CFG_W-1:1], 1'b0});
    if (t > h) t = h;
    return t;
  endfunction

  // configuration, kept in effective form
  logic [CFG_W-1:0] rraw_q, rraw_d;
  logic [HW-1:0]    h_q, h_d, r_q, r_d, half_q;

  always_comb begin
    h_d    = h_q;
    rraw_d = rraw_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_HEAD: h_d    = sat_head(cfg_wdata_i);
        CFG_ROT:  rraw_d = cfg_wdata_i;
      endcase
    end
    r_d = sat_rot(rraw_d, h_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q    <= sat_head(HEAD_RST);
      rraw_q <= ROT_RST;
      r_q    <= sat_rot(ROT_RST, sat_head(HEAD_RST));
      half_q <= sat_rot(ROT_RST, sat_head(HEAD_RST)) >> 1;
    end else begin
      h_q    <= h_d;
      rraw_q <= rraw_d;
      r_q    <= r_d;
      half_q <= r_d >> 1;
    end
  end

  // element position and class
  logic [CntW-1:0] cnt_q;
  logic [HW-1:0]   c, j;
  logic            last, is_store, is_pair, acc;
  logic [OccW-1:0] occ_q;
  logic            pop;

  assign c        = (HW'(cnt_q) >= h_q) ? '0 : HW'(cnt_q);
  assign last     = c == (h_q - HW'(1));
  assign is_store = c < half_q;
  assign is_pair  = !is_store && (c < r_q);
  assign j        = c - half_q;
  assign in_stall_o = occ_q == OccW'(OQ_DEPTH);
  assign acc      = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (acc) begin
      cnt_q <= last ? '0 : CntW'(c + HW'(1));
    end
  end

  // items with results in flight or queued
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      unique case ({acc && !is_store, pop})
        2'b10:   occ_q <= occ_q + OccW'(1);
        2'b01:   occ_q <= occ_q - OccW'(1);
        default: occ_q <= occ_q;
      endcase
    end
  end

  // first-half store: write at position, partner read as the item is accepted, ready for stage 1 of the math
  // (an entry is always written by an earlier item than the one reading it)
  logic [15:0] xl;

  rspu_ram #(
    .Width(16),
    .Depth(StDep)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (acc && is_store),
    .waddr_i(AW'(c)),
    .wdata_i(in_word_i.element_value),
    .re_i   (acc && is_pair),
    .raddr_i(AW'(j)),
    .rdata_o(xl)
  );

  rot_ctl_t ctl;
  logic     ent_vld;
  ent_t     ent;

  assign ctl.pair  = is_pair;
  assign ctl.pos_a = is_pair ? POS_W'(j) : POS_W'(c);
  assign ctl.pos_b = POS_W'(c);
  assign ctl.last  = last;

  rspu_rot u_rot (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .vld_i    (acc && !is_store),
    .ctl_i    (ctl),
    .x_i      (in_word_i.element_value),
    .cos_i    (in_word_i.cos_value),
    .sin_i    (in_word_i.sin_value),
    .xl_i     (xl),
    .ent_vld_o(ent_vld),
    .ent_o    (ent)
  );

  rspu_outq #(
    .Depth(OQ_DEPTH)
  ) u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_vld_i   (ent_vld),
    .wr_ent_i   (ent),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o),
    .pop_o      (pop)
  );

endmodule

/* design/rspu_ram.sv */
module rspu_ram #(
  parameter int Width = 16,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/rspu_rot.sv */
module rspu_rot (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              vld_i,
  input  rspu_pkg::rot_ctl_t ctl_i,
  input  logic [15:0]       x_i,
  input  logic [15:0]       cos_i,
  input  logic [15:0]       sin_i,
  input  logic [15:0]       xl_i,
  output logic              ent_vld_o,
  output rspu_pkg::ent_t    ent_o
);
  import rspu_pkg::*;

  // fp16 helpers
  function automatic logic is_nan(logic [15:0] a);
    return (a[14:10] == 5'h1F) && (a[9:0] != 10'd0);
  endfunction

  function automatic logic is_inf(logic [15:0] a);
    return a[14:0] == HALF_INF;
  endfunction

  function automatic logic [10:0] dec_mag(logic [15:0] a);
    return (a[14:10] == 5'd0) ? {1'b0, a[9:0]} : {1'b1, a[9:0]};
  endfunction

  // exponent of the magnitude's lsb
  function automatic logic signed [7:0] dec_exp(logic [15:0] a);
    return (a[14:10] == 5'd0) ? -8'sd24 : $signed({3'b000, a[14:10]}) - 8'sd25;
  endfunction

  // round sign * mag * 2^exp to fp16, nearest even
  function automatic logic [15:0] rnd(logic sgn, logic [25:0] mag, logic signed [7:0] exp);
    logic signed [9:0] len;
    logic signed [9:0] q;
    logic signed [9:0] sh;
    logic signed [9:0] fld;
    logic [25:0]       tmp;
    logic [11:0]       mant;
    logic              grd;
    logic              stk;
    len = '0;
    for (int i = 0; i < 26; i++) begin
      if (mag[i]) len = 10'(i + 1);
    end
    q = 10'(exp) + len - 10'sd11;
    if (q < -10'sd24) q = -10'sd24;
    sh = q - 10'(exp);
    if (sh <= 10'sd0) begin
      mant = 12'(mag << 5'(-sh));
    end else begin
      tmp  = mag >> (sh[4:0] - 5'd1);
      grd  = tmp[0];
      stk  = |(mag & ((26'd1 << (sh[4:0] - 5'd1)) - 26'd1));
      mant = 12'(mag >> sh[4:0]);
      if (grd && (stk || mant[0])) mant = mant + 12'd1;
    end
    if (mant == 12'h800) begin
      mant = 12'h400;
      q    = q + 10'sd1;
    end
    fld = q + 10'sd25;
    if (mag == 26'd0) return {sgn, 15'd0};
    if (mant < 12'h400) return {sgn, 5'd0, mant[9:0]};
    if (fld >= 10'sd31) return {sgn, HALF_INF};
    return {sgn, fld[4:0], mant[9:0]};
  endfunction

  // stage 1: item registered, stored partner arrives from the RAM
  logic        v1_q;
  rot_ctl_t    ctl1_q;
  logic [15:0] x1_q, c1_q, s1_q;

  // stage 2: raw products
  logic             v2_q;
  rot_ctl_t         ctl2_q;
  logic [15:0]      x2_q;
  logic             p_sgn_q [4];
  logic [21:0]      p_mag_q [4];
  logic signed [7:0] p_exp_q [4];
  logic             p_spc_q [4];
  logic [15:0]      p_spv_q [4];

  // stage 3: rounded products
  logic        v3_q;
  rot_ctl_t    ctl3_q;
  logic [15:0] x3_q;
  logic [15:0] r_q [4];

  // stage 4: aligned addends
  logic             v4_q;
  rot_ctl_t         ctl4_q;
  logic [15:0]      x4_q;
  logic [24:0]      al_a_q [2];
  logic [24:0]      al_b_q [2];
  logic             al_sa_q [2];
  logic             al_sb_q [2];
  logic             al_zs_q [2];
  logic signed [7:0] al_exp_q [2];
  logic             al_spc_q [2];
  logic [15:0]      al_spv_q [2];

  // stage 5: exact sums
  logic             v5_q;
  rot_ctl_t         ctl5_q;
  logic [15:0]      x5_q;
  logic             sm_sgn_q [2];
  logic [25:0]      sm_mag_q [2];
  logic signed [7:0] sm_exp_q [2];
  logic             sm_spc_q [2];
  logic [15:0]      sm_spv_q [2];

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v1_q <= vld_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // control and pass-through value ride along
  always_ff @(posedge clk_i) begin
    ctl1_q <= ctl_i;
    x1_q   <= x_i;
    c1_q   <= cos_i;
    s1_q   <= sin_i;
    ctl2_q <= ctl1_q;
    x2_q   <= x1_q;
    ctl3_q <= ctl2_q;
    x3_q   <= x2_q;
    ctl4_q <= ctl3_q;
    x4_q   <= x3_q;
    ctl5_q <= ctl4_q;
    x5_q   <= x4_q;
  end

  // stage 1 -> 2: four mantissa products
  logic [15:0]       ma [4];
  logic [15:0]       mb [4];
  logic              p_sgn_d [4];
  logic [21:0]       p_mag_d [4];
  logic signed [7:0] p_exp_d [4];
  logic              p_spc_d [4];
  logic [15:0]       p_spv_d [4];

  always_comb begin
    ma[0] = xl_i; mb[0] = c1_q;
    ma[1] = x1_q; mb[1] = s1_q;
    ma[2] = x1_q; mb[2] = c1_q;
    ma[3] = xl_i; mb[3] = s1_q;
    for (int k = 0; k < 4; k++) begin
      p_sgn_d[k] = ma[k][15] ^ mb[k][15];
      p_mag_d[k] = dec_mag(ma[k]) * dec_mag(mb[k]);
      p_exp_d[k] = dec_exp(ma[k]) + dec_exp(mb[k]);
      p_spc_d[k] = 1'b0;
      p_spv_d[k] = HALF_QNAN;
      if (is_nan(ma[k]) || is_nan(mb[k])) begin
        p_spc_d[k] = 1'b1;
      end else if (is_inf(ma[k]) || is_inf(mb[k])) begin
        p_spc_d[k] = 1'b1;
        if ((ma[k][14:0] != 15'd0) && (mb[k][14:0] != 15'd0)) begin
          p_spv_d[k] = {p_sgn_d[k], HALF_INF};
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 4; k++) begin
      p_sgn_q[k] <= p_sgn_d[k];
      p_mag_q[k] <= p_mag_d[k];
      p_exp_q[k] <= p_exp_d[k];
      p_spc_q[k] <= p_spc_d[k];
      p_spv_q[k] <= p_spv_d[k];
    end
  end

  // stage 2 -> 3: round products
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 4; k++) begin
      r_q[k] <= p_spc_q[k] ? p_spv_q[k] : rnd(p_sgn_q[k], 26'(p_mag_q[k]), p_exp_q[k]);
    end
  end

  // stage 3 -> 4: specials and alignment; lo = p0 - p1, hi = p2 + p3
  logic [15:0]       ad_a [2];
  logic [15:0]       ad_b [2];
  logic [15:0]       big, sml;
  logic signed [7:0] ea, eb, dexp;
  logic [24:0]       bfull;
  logic [24:0]       al_a_d [2];
  logic [24:0]       al_b_d [2];
  logic              al_sa_d [2];
  logic              al_sb_d [2];
  logic              al_zs_d [2];
  logic signed [7:0] al_exp_d [2];
  logic              al_spc_d [2];
  logic [15:0]       al_spv_d [2];

  always_comb begin
    ad_a[0] = r_q[0];
    ad_b[0] = r_q[1] ^ 16'h8000;
    ad_a[1] = r_q[2];
    ad_b[1] = r_q[3];
    big   = '0;
    sml   = '0;
    ea    = '0;
    eb    = '0;
    dexp  = '0;
    bfull = '0;
    for (int k = 0; k < 2; k++) begin
      ea = dec_exp(ad_a[k]);
      eb = dec_exp(ad_b[k]);
      if (ea >= eb) begin
        big = ad_a[k];
        sml = ad_b[k];
        dexp = ea - eb;
        al_exp_d[k] = ea - 8'sd14;
      end else begin
        big = ad_b[k];
        sml = ad_a[k];
        dexp = eb - ea;
        al_exp_d[k] = eb - 8'sd14;
      end
      al_a_d[k]  = {dec_mag(big), 14'd0};
      bfull      = {dec_mag(sml), 14'd0};
      if (dexp >= 8'sd25) begin
        al_b_d[k] = {24'd0, |dec_mag(sml)};
      end else begin
        al_b_d[k] = (bfull >> dexp[4:0]) |
                    {24'd0, |(bfull & ((25'd1 << dexp[4:0]) - 25'd1))};
      end
      al_sa_d[k] = big[15];
      al_sb_d[k] = sml[15];
      al_zs_d[k] = ad_a[k][15] & ad_b[k][15];
      // NaN, infinities
      al_spc_d[k] = 1'b1;
      al_spv_d[k] = HALF_QNAN;
      priority if (is_nan(ad_a[k]) || is_nan(ad_b[k])) begin
        al_spv_d[k] = HALF_QNAN;
      end else if (is_inf(ad_a[k]) && is_inf(ad_b[k])) begin
        al_spv_d[k] = (ad_a[k][15] != ad_b[k][15]) ? HALF_QNAN : ad_a[k];
      end else if (is_inf(ad_a[k])) begin
        al_spv_d[k] = ad_a[k];
      end else if (is_inf(ad_b[k])) begin
        al_spv_d[k] = ad_b[k];
      end else begin
        al_spc_d[k] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 2; k++) begin
      al_a_q[k]   <= al_a_d[k];
      al_b_q[k]   <= al_b_d[k];
      al_sa_q[k]  <= al_sa_d[k];
      al_sb_q[k]  <= al_sb_d[k];
      al_zs_q[k]  <= al_zs_d[k];
      al_exp_q[k] <= al_exp_d[k];
      al_spc_q[k] <= al_spc_d[k];
      al_spv_q[k] <= al_spv_d[k];
    end
  end

  // stage 4 -> 5: magnitude add or subtract
  logic [25:0] sm_mag_d [2];
  logic        sm_sgn_d [2];

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      if (al_sa_q[k] == al_sb_q[k]) begin
        sm_mag_d[k] = 26'(al_a_q[k]) + 26'(al_b_q[k]);
        sm_sgn_d[k] = al_sa_q[k];
      end else if (al_a_q[k] >= al_b_q[k]) begin
        sm_mag_d[k] = 26'(al_a_q[k] - al_b_q[k]);
        sm_sgn_d[k] = al_sa_q[k];
      end else begin
        sm_mag_d[k] = 26'(al_b_q[k] - al_a_q[k]);
        sm_sgn_d[k] = al_sb_q[k];
      end
      // exact zero: negative only when both addends are -0
      if (sm_mag_d[k] == 26'd0) sm_sgn_d[k] = al_zs_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 2; k++) begin
      sm_sgn_q[k] <= sm_sgn_d[k];
      sm_mag_q[k] <= sm_mag_d[k];
      sm_exp_q[k] <= al_exp_q[k];
      sm_spc_q[k] <= al_spc_q[k];
      sm_spv_q[k] <= al_spv_q[k];
    end
  end

  // stage 5: final rounding, entry to the queue
  logic [15:0] res [2];

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      res[k] = sm_spc_q[k] ? sm_spv_q[k] : rnd(sm_sgn_q[k], sm_mag_q[k], sm_exp_q[k]);
    end
  end

  assign ent_vld_o   = v5_q;
  assign ent_o.pair  = ctl5_q.pair;
  assign ent_o.pos_a = ctl5_q.pos_a;
  assign ent_o.val_a = ctl5_q.pair ? res[0] : x5_q;
  assign ent_o.pos_b = ctl5_q.pos_b;
  assign ent_o.val_b = res[1];
  assign ent_o.last  = ctl5_q.last;

endmodule

/* design/rspu_outq.sv */
module rspu_outq #(
  parameter int Depth = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_vld_i,
  input  rspu_pkg::ent_t      wr_ent_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rspu_pkg::out_word_t out_word_o,
  output logic                pop_o
);
  import rspu_pkg::*;

  localparam int AW = $clog2(Depth);

  ent_t          mem_q [Depth];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0]   cnt_q;
  logic          sec_q;
  ent_t          head;
  logic          take;

  assign head        = mem_q[rp_q];
  assign out_valid_o = cnt_q != '0;
  assign take        = out_valid_o && !out_stall_i;
  assign pop_o       = take && (!head.pair || sec_q);

  // word select: first or second result of the head entry
  assign out_word_o.position     = sec_q ? head.pos_b : head.pos_a;
  assign out_word_o.result_value = sec_q ? head.val_b : head.val_a;
  assign out_word_o.run_last     = !head.pair || sec_q;
  assign out_word_o.head_last    = head.last;

  always_ff @(posedge clk_i) begin
    if (wr_vld_i) begin
      mem_q[wp_q] <= wr_ent_i;
    end
  end

  // pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
      sec_q <= 1'b0;
    end else begin
      if (wr_vld_i) wp_q <= wp_q + AW'(1);
      if (pop_o) rp_q <= rp_q + AW'(1);
      if (take) sec_q <= !pop_o;
      unique case ({wr_vld_i, pop_o})
        2'b10:   cnt_q <= cnt_q + (AW+1)'(1);
        2'b01:   cnt_q <= cnt_q - (AW+1)'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

/* design/rspu_chk.sv */
module rspu_chk (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input rspu_pkg::out_word_t out_word_o
);

  // a stalled word stays put
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled output word changed");

  // first word of a pair is followed at once by its closing word of the same head state
  a_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_word_o.run_last |=>
      out_valid_o && out_word_o.run_last &&
      (out_word_o.head_last == $past(out_word_o.head_last)))
    else $error("pair word not followed by its partner");

  // nothing to deliver right out of reset
  a_rst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("output valid right after reset");

endmodule

bind rope_split_half_partial_unit rspu_chk u_chk (.*);

/* dv/rope_split_half_partial_unit_test.sv */
`timescale 1ns / 100ps

module rope_split_half_partial_unit_test;
  import rspu_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_word_t    in_word_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_word_t   out_word_o;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [9:0]  cfg_wdata_i = '0;

  rope_split_half_partial_unit dut (.*);

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // words waiting to be sent, and result words still owed by the block
  in_word_t  pending_words[$];
  out_word_t owed_results[$];
  int        err_count = 0;
  int        send_idle_pct = 0;
  int        stall_pct = 0;
  int        hold_req = 0;
  int        hold_done = 0;
  int        hold_left = 0;

  // mirror of the block's registers and state
  logic [9:0]  head_reg = HEAD_RST;
  logic [9:0]  rot_reg = ROT_RST;
  int          elem_pos = 0;
  logic [15:0] lo_store[256];

  // fp16 arithmetic, round to nearest even
  function automatic bit is_nan16(logic [15:0] a);
    return a[14:10] == 5'h1F && a[9:0] != 0;
  endfunction

  function automatic bit is_inf16(logic [15:0] a);
    return a[14:0] == HALF_INF;
  endfunction

  function automatic void unpack16(logic [15:0] a, output longint mag, output int ex);
    if (a[14:10] == 0) begin
      mag = a[9:0];
      ex = -24;
    end else begin
      mag = {1'b1, a[9:0]};
      ex = int'(a[14:10]) - 25;
    end
  endfunction

  function automatic logic [15:0] round16(bit neg, longint mag, int ex);
    logic [15:0] sgn;
    int len, q, sh, fld;
    longint t, mant, rem, halfq;
    sgn = {neg, 15'd0};
    if (mag == 0) return sgn;
    len = 0;
    for (t = mag; t != 0; t = t >> 1) len++;
    q = ex + len - 11;
    if (q < -24) q = -24;
    sh = q - ex;
    if (sh <= 0) mant = mag << (-sh);
    else if (sh > 62) mant = 0;
    else begin
      rem = mag & ((64'd1 << sh) - 1);
      halfq = 64'd1 << (sh - 1);
      mant = mag >> sh;
      if (rem > halfq || (rem == halfq && mant[0])) mant++;
    end
    if (mant == 'h800) begin
      mant = 'h400;
      q++;
    end
    if (mant < 'h400) return sgn | mant[15:0];
    fld = q + 25;
    if (fld >= 31) return sgn | {1'b0, HALF_INF};
    return sgn | {1'b0, fld[4:0], mant[9:0]};
  endfunction

  function automatic logic [15:0] mul16(logic [15:0] a, logic [15:0] b);
    bit sg;
    longint ma, mb;
    int ea, eb;
    sg = a[15] ^ b[15];
    if (is_nan16(a) || is_nan16(b)) return HALF_QNAN;
    if (is_inf16(a) || is_inf16(b)) begin
      if (a[14:0] == 0 || b[14:0] == 0) return HALF_QNAN;
      return {sg, HALF_INF};
    end
    unpack16(a, ma, ea);
    unpack16(b, mb, eb);
    return round16(sg, ma * mb, ea + eb);
  endfunction

  function automatic logic [15:0] add16(logic [15:0] a, logic [15:0] b);
    longint ma, mb, va, vb, s;
    int ea, eb;
    if (is_nan16(a) || is_nan16(b)) return HALF_QNAN;
    if (is_inf16(a) && is_inf16(b)) return (a[15] ^ b[15]) ? HALF_QNAN : a;
    if (is_inf16(a)) return a;
    if (is_inf16(b)) return b;
    unpack16(a, ma, ea);
    unpack16(b, mb, eb);
    va = ma << (ea + 24);
    vb = mb << (eb + 24);
    if (a[15]) va = -va;
    if (b[15]) vb = -vb;
    s = va + vb;
    if (s == 0) return (a[15] & b[15]) ? 16'h8000 : 16'h0000;
    if (s < 0) return round16(1'b1, -s, -24);
    return round16(1'b0, s, -24);
  endfunction

  // rotation of one accepted element: stores first-half values, owes result words
  task automatic rotate_element(in_word_t w);
    int hsz, rot, half, c, j;
    bit last;
    logic [15:0] xl, lo, hi;
    out_word_t r;
    hsz = head_reg;
    if (hsz < 2) hsz = 2;
    if (hsz > MAX_HEAD_DEF) hsz = MAX_HEAD_DEF;
    rot = rot_reg & ~1;
    if (rot > hsz) rot = hsz;
    half = rot / 2;
    c = (elem_pos >= hsz) ? 0 : elem_pos;
    last = (c == hsz - 1);
    if (c < half) begin
      lo_store[c] = w.element_value;
    end else if (c < rot) begin
      j = c - half;
      xl = lo_store[j];
      lo = add16(mul16(xl, w.cos_value), mul16(w.element_value, w.sin_value) ^ 16'h8000);
      hi = add16(mul16(w.element_value, w.cos_value), mul16(xl, w.sin_value));
      r.position = j[8:0];
      r.result_value = lo;
      r.run_last = 1'b0;
      r.head_last = last;
      owed_results.push_back(r);
      r.position = c[8:0];
      r.result_value = hi;
      r.run_last = 1'b1;
      owed_results.push_back(r);
    end else begin
      r.position = c[8:0];
      r.result_value = w.element_value;
      r.run_last = 1'b1;
      r.head_last = last;
      owed_results.push_back(r);
    end
    elem_pos = last ? 0 : c + 1;
  endtask

  // driver: offers pending words, holds a stalled word steady
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        rotate_element(in_word_i);
        void'(pending_words.pop_front());
      end
      if (in_valid_i && in_stall_o) begin
        in_valid_i <= 1'b1;
      end else if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        in_word_i <= pending_words[0];
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // long hold-off so the result queue fills and backs up the input
  always @(posedge clk_i) begin
    if (hold_req != hold_done) begin
      hold_done <= hold_req;
      hold_left <= 300;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor: checks result words against what is owed, drives stall
  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (owed_results.size() == 0) begin
          $display("%0t: unexpected result word %h", $time, out_word_o);
          err_count++;
        end else begin
          want = owed_results.pop_front();
          if (out_word_o.position !== want.position) begin
            $display("%0t: position exp %0d got %0d", $time, want.position,
                     out_word_o.position);
            err_count++;
          end
          if (out_word_o.result_value !== want.result_value) begin
            $display("%0t: result_value exp %h got %h", $time, want.result_value,
                     out_word_o.result_value);
            err_count++;
          end
          if (out_word_o.run_last !== want.run_last) begin
            $display("%0t: run_last exp %b got %b", $time, want.run_last,
                     out_word_o.run_last);
            err_count++;
          end
          if (out_word_o.head_last !== want.head_last) begin
            $display("%0t: head_last exp %b got %b", $time, want.head_last,
                     out_word_o.head_last);
            err_count++;
          end
        end
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [9:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    if (idx == CFG_HEAD) head_reg = val;
    else rot_reg = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // wait until every word is sent and every result word has come
  task automatic drain();
    while (pending_words.size() > 0 || in_valid_i || owed_results.size() > 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic push_word(logic [15:0] x, logic [15:0] c, logic [15:0] s);
    in_word_t w;
    w.element_value = x;
    w.cos_value = c;
    w.sin_value = s;
    pending_words.push_back(w);
  endtask

  // mostly random bits, sometimes an fp16 special value
  function automatic logic [15:0] pick_half();
    logic [15:0] specials[13] = '{16'h0000, 16'h8000, 16'h7C00, 16'hFC00, 16'h7E00,
                                  16'h7C01, 16'h0001, 16'h8001, 16'h03FF, 16'h7BFF,
                                  16'hFBFF, 16'h3C00, 16'hBC00};
    if ($urandom_range(99) < 15) return specials[$urandom_range(12)];
    return 16'($urandom());
  endfunction

  // stimulus
  initial begin
    int heads_n, hsz;
    logic [9:0] head_vals[10] = '{10'd16, 10'd12, 10'd0, 10'd1023, 10'd32,
                                  10'd20, 10'd9, 10'd64, 10'd2, 10'd40};
    logic [9:0] rot_vals[10] = '{10'd16, 10'd6, 10'd2, 10'd1023, 10'd1,
                                 10'd24, 10'd5, 10'd64, 10'd0, 10'd17};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // rotation specials: NaN, overflow, signed zeros, inf times zero
    write_reg(CFG_HEAD, 10'd8);
    write_reg(CFG_ROT, 10'd8);
    push_word(16'h3C00, 16'h0000, 16'h0000);
    push_word(16'h7BFF, 16'hFFFF, 16'hFFFF);
    push_word(16'h8000, 16'h0000, 16'h0000);
    push_word(16'h7C00, 16'h0000, 16'h0000);
    push_word(16'h0001, 16'h7C01, 16'h3C00);
    push_word(16'h7BFF, 16'h7BFF, 16'h0000);
    push_word(16'h8000, 16'h3C00, 16'h0000);
    push_word(16'hFC00, 16'h0000, 16'h3C00);
    drain();
    // subnormals and infinities, then head lowered mid-head
    write_reg(CFG_ROT, 10'd4);
    push_word(16'h03FF, 16'h0000, 16'h0000);
    push_word(16'h8001, 16'h0000, 16'h0000);
    push_word(16'hFBFF, 16'h0001, 16'h8001);
    push_word(16'h7C00, 16'h3C00, 16'hBC00);
    push_word(16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_word(16'h0000, 16'h0000, 16'h0000);
    drain();
    // counter past the new head end restarts at position 0
    write_reg(CFG_HEAD, 10'd4);
    for (int i = 0; i < 4; i++) push_word(pick_half(), pick_half(), pick_half());
    drain();
    // rotary size of zero: everything passes
    write_reg(CFG_ROT, 10'd1);
    for (int i = 0; i < 4; i++) push_word(pick_half(), pick_half(), pick_half());
    drain();

    // random phases, cycling through the idle modes
    for (int p = 0; p < 10; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0; stall_pct = 0; end
        1: begin send_idle_pct = 77; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 77; end
        default: begin send_idle_pct = 33; stall_pct = 33; end
      endcase
      write_reg(CFG_HEAD, head_vals[p]);
      write_reg(CFG_ROT, rot_vals[p]);
      hsz = head_vals[p];
      if (hsz < 2) hsz = 2;
      if (hsz > MAX_HEAD_DEF) hsz = MAX_HEAD_DEF;
      heads_n = (hsz >= 150) ? 1 : 150 / hsz;
      if (p == 4) hold_req++;
      for (int h = 0; h < heads_n; h++)
        for (int i = 0; i < hsz; i++) push_word(pick_half(), pick_half(), pick_half());
      drain();
    end

    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

/* files.f */
design/rspu_pkg.sv
design/rspu_ram.sv
design/rspu_rot.sv
design/rspu_outq.sv
design/rope_split_half_partial_unit.sv
design/rspu_chk.sv
dv/rope_split_half_partial_unit_test.sv
